### hdl/tse_pkg.sv
// Package for the TDMA schedule expander: sizes, codes and state type.
// Shared by the slot table logic in tdma_schedule_expander.
// Depends on nothing.
`timescale 1ns / 1ps

package tse_pkg;

   // Table depth and stored stream width.
   localparam int MAX_SLOTS   = 1024;
   localparam int STREAM_BITS = 24;

   // Field widths on the ports.
   localparam int NODE_W     = 8;
   localparam int CFG_W      = 11;
   localparam int PERIOD_W   = 10;
   localparam int FIRST_W    = 10;
   localparam int RSLOT_W    = 10;
   localparam int STREAM_W   = 24;
   localparam int ACTION_W   = 3;
   localparam int CMD_W      = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;

   // Derived internal widths.
   localparam int SLOT_BITS = $clog2(MAX_SLOTS);
   localparam int TOTAL_W   = $clog2(MAX_SLOTS + 1);
   localparam int PROD_W    = 2 * CFG_W;
   localparam int STEP_W    = PERIOD_W + CFG_W;
   localparam int CNT_W     = ((TOTAL_W > STEP_W) ? TOTAL_W : STEP_W) + 1;
   localparam int ENTRY_W   = ACTION_W + STREAM_BITS;

   // Packed offsets of the request item fields inside req_tdata.
   localparam int OFS_SRC    = 0;
   localparam int OFS_DST    = OFS_SRC + NODE_W;
   localparam int OFS_TX     = OFS_DST + NODE_W;
   localparam int OFS_RX     = OFS_TX + NODE_W;
   localparam int OFS_PERIOD = OFS_RX + NODE_W;
   localparam int OFS_FIRST  = OFS_PERIOD + PERIOD_W;
   localparam int OFS_STREAM = OFS_FIRST + FIRST_W;
   localparam int OFS_RSLOT  = OFS_STREAM + STREAM_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SLEEP       = 3'd0,
      ACT_SEND_STREAM = 3'd1,
      ACT_RECV_STREAM = 3'd2,
      ACT_SEND_BUFFER = 3'd3,
      ACT_RECV_BUFFER = 3'd4
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NODE_ID        = 2'd0,
      CSR_SLOTS_IN_TILE  = 2'd1,
      CSR_SCHEDULE_TILES = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_FILL,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

endpackage

### hdl/tse_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the slot table of the TDMA schedule expander.
// Depends on nothing.
`timescale 1ns / 1ps

module tse_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tdma_schedule_expander.sv
// Top level of the TDMA schedule expander: control, configuration and slot table.
// Depends on tse_pkg and tse_ram.
`timescale 1ns / 1ps

// The block keeps one action and stream identifier per slot in a MAX_SLOTS
// deep table memory and takes one item at a time. After reset it sweeps the
// table to sleep, one entry per cycle, before req_tready rises. A clear item
// runs the same sweep. An add item that involves this node passes through
// ST_SETUP and ST_FILL and writes its slots one at a time, since the table
// memory has one write port; an add whose step is zero writes at most one
// slot, and an add that does not involve this node writes nothing.
// A read item passes through ST_RD_ADDR and ST_RD_DATA for the registered
// memory read, and its result waits in an output register, so the next item
// can start while the result has not been taken. The slot count derived from
// the configuration is registered in total_ff.
module tdma_schedule_expander
   import tse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // From bit 0: src_node, dst_node, tx_node, rx_node, period_tiles,
   // first_slot, stream_ident, read_slot, two zero bits.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd.
   input  logic [CMD_W-1:0]      req_tuser,
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0: slot_action, slot_stream, five zero bits.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // in_range.
   output logic                  rsp_tuser,
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   // Request fields.
   cmd_type               req_cmd;
   logic [NODE_W-1:0]     req_src;
   logic [NODE_W-1:0]     req_dst;
   logic [NODE_W-1:0]     req_tx;
   logic [NODE_W-1:0]     req_rx;
   logic [PERIOD_W-1:0]   req_period;
   logic [FIRST_W-1:0]    req_first;
   logic [STREAM_W-1:0]   req_stream;
   logic [RSLOT_W-1:0]    req_rslot;
   logic                  req_acc;

   // Configuration registers and the derived slot count.
   logic [NODE_W-1:0]     node_id_ff;
   logic [CFG_W-1:0]      slots_in_tile_ff;
   logic [CFG_W-1:0]      schedule_tiles_ff;
   logic [PROD_W-1:0]     total_prod;
   logic [TOTAL_W-1:0]    total_in;
   logic [TOTAL_W-1:0]    total_ff;

   // Sequencer.
   state_type             state_ff;
   state_type             state_in;
   logic [SLOT_BITS-1:0]  clr_ff;
   logic [SLOT_BITS-1:0]  clr_in;
   logic [CNT_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      ptr_in;
   logic [STEP_W-1:0]     step_ff;
   logic                  clr_last;
   logic                  fill_hit;

   // Item held during its work.
   action_type            act_sel;
   logic                  act_hit;
   action_type            act_ff;
   logic [STREAM_BITS-1:0] stream_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [RSLOT_W-1:0]    rslot_ff;
   logic                  beyond_ff;

   // Table memory access.
   logic                  mem_we;
   logic [SLOT_BITS-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0]    mem_wr_data;
   logic                  mem_rd_en;
   logic [ENTRY_W-1:0]    mem_rd_data;

   // Output register.
   logic                  rsp_load;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ACTION_W-1:0]   rsp_action_ff;
   logic [STREAM_W-1:0]   rsp_stream_ff;
   logic                  rsp_range_ff;

   // Unpack the request item.
   assign req_cmd    = cmd_type'(req_tuser);
   assign req_src    = req_tdata[OFS_SRC    +: NODE_W];
   assign req_dst    = req_tdata[OFS_DST    +: NODE_W];
   assign req_tx     = req_tdata[OFS_TX     +: NODE_W];
   assign req_rx     = req_tdata[OFS_RX     +: NODE_W];
   assign req_period = req_tdata[OFS_PERIOD +: PERIOD_W];
   assign req_first  = req_tdata[OFS_FIRST  +: FIRST_W];
   assign req_stream = req_tdata[OFS_STREAM +: STREAM_W];
   assign req_rslot  = req_tdata[OFS_RSLOT  +: RSLOT_W];
   assign req_acc    = req_tvalid & req_tready;

   // Configuration register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff        <= '0;
         slots_in_tile_ff  <= CFG_W'(1);
         schedule_tiles_ff <= CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NODE_ID:        node_id_ff        <= csr_wdata[NODE_W-1:0];
            CSR_SLOTS_IN_TILE:  slots_in_tile_ff  <= csr_wdata;
            CSR_SCHEDULE_TILES: schedule_tiles_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Total slot count, saturated at the table depth.
   assign total_prod = schedule_tiles_ff * slots_in_tile_ff;
   assign total_in   = (total_prod > PROD_W'(MAX_SLOTS)) ? TOTAL_W'(MAX_SLOTS)
                                                         : TOTAL_W'(total_prod);

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // Action for this node; receive wins over transmit.
   always_comb begin
      act_hit = 1'b1;
      if (req_rx == node_id_ff) begin
         act_sel = (req_dst == node_id_ff) ? ACT_RECV_STREAM : ACT_RECV_BUFFER;
      end else if (req_tx == node_id_ff) begin
         act_sel = (req_src == node_id_ff) ? ACT_SEND_STREAM : ACT_SEND_BUFFER;
      end else begin
         act_sel = ACT_SLEEP;
         act_hit = 1'b0;
      end
   end

   assign clr_last = (clr_ff == SLOT_BITS'(MAX_SLOTS - 1));
   assign fill_hit = (ptr_ff < CNT_W'(total_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_cmd)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_ADD:   state_in = act_hit ? ST_SETUP : ST_IDLE;
                  CMD_READ:  state_in = ST_RD_ADDR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (!fill_hit || (step_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready  = 1'b0;
      mem_we      = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_FILL: begin
            mem_we      = fill_hit;
            mem_wr_addr = ptr_ff[SLOT_BITS-1:0];
            mem_wr_data = {stream_ff, act_ff};
         end
         ST_RD_ADDR: begin
            mem_rd_en = 1'b1;
         end
         ST_RD_DATA: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   // Clear sweep counter and fill pointer.
   always_comb begin
      clr_in = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + SLOT_BITS'(1);
      end else if (req_acc) begin
         clr_in = '0;
      end
      ptr_in = ptr_ff;
      if (req_acc) begin
         ptr_in = CNT_W'(req_first);
      end else if (state_ff == ST_FILL) begin
         ptr_in = ptr_ff + CNT_W'(step_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   // Item payload held during its work.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (req_acc) begin
         act_ff    <= act_sel;
         stream_ff <= STREAM_BITS'(req_stream);
         period_ff <= req_period;
         rslot_ff  <= req_rslot;
         beyond_ff <= (int'(req_rslot) >= MAX_SLOTS);
      end
      if (state_ff == ST_SETUP) begin
         step_ff <= period_ff * slots_in_tile_ff;
      end
   end

   // Slot table.
   tse_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (SLOT_BITS'(rslot_ff)),
      .rd_data (mem_rd_data)
   );

   // Result register; a slot past the table reads as sleep.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_action_ff <= beyond_ff ? ACTION_W'(ACT_SLEEP) : mem_rd_data[ACTION_W-1:0];
         rsp_stream_ff <= beyond_ff ? '0 : STREAM_W'(mem_rd_data[ENTRY_W-1:ACTION_W]);
         rsp_range_ff  <= (TOTAL_W'(rslot_ff) < total_ff) && !beyond_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_stream_ff, rsp_action_ff});
   assign rsp_tuser  = rsp_range_ff;

`ifndef SYNTH
   // Fill writes stay below the scheduled slot count.
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && mem_we) |-> (ptr_ff < CNT_W'(total_ff)))
      else $error("fill write beyond the total slot count");

   // The clear sweep ends after its last entry.
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_last) |=> (state_ff == ST_IDLE))
      else $error("clear sweep did not end after the last entry");

   // Read data is only taken after the memory read was issued.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ($past(state_ff) == ST_RD_ADDR || $past(state_ff) == ST_RD_DATA))
      else $error("result loaded without a preceding table read");

   // No new item starts while a table sweep or fill is running.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_FILL) |-> !req_tready)
      else $error("item accepted during a table write pass");
`endif

endmodule
